@@ hw/rtl/crmc_pkg.sv @@
// ----------------------------------------------------------------------------
// crmc_pkg: shared types and constants of the canonical row mode counter
// Sizes of the pattern table, the cell groups and the per-cell control word.
// ----------------------------------------------------------------------------
package crmc_pkg;

  localparam int ROW_BITS    = 64;
  localparam int WIDTH_W     = 7;
  localparam int NUM_CELLS   = 256;
  localparam int GROUP_SIZE  = 16;
  localparam int NUM_GROUPS  = NUM_CELLS / GROUP_SIZE;
  localparam int CNT_W       = 9;

  localparam logic [CNT_W-1:0]   CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [WIDTH_W-1:0] WIDTH_DEFAULT = WIDTH_W'(ROW_BITS);

  // Control broadcast from the sequencer to every table cell
  typedef struct packed {
    logic clear;  // drop the entry (first row of a matrix)
    logic cmp;    // capture the match flag
    logic inc;    // bump the count of the matching entry
    logic ins;    // store the key in the first free entry
  } cell_ctl_t;

endpackage

@@ hw/rtl/crmc_cell.sv @@
// ----------------------------------------------------------------------------
// crmc_cell: one entry of the pattern table
// Holds a key, its count and a valid bit; finds the insert point from the
// valid bit of its left neighbor, so the used entries always form a prefix.
// ----------------------------------------------------------------------------
module crmc_cell
  import crmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cell_ctl_t           ctl,
  input  logic [ROW_BITS-1:0] key_in,
  input  logic                prev_valid,
  output logic                valid,
  output logic                hit,
  output logic [CNT_W-1:0]    cnt_sel
);

  logic [ROW_BITS-1:0] key;
  logic [CNT_W-1:0]    count;
  logic                eff_valid;

  // A first row invalidates the entry before it is compared
  assign eff_valid = valid && !ctl.clear;

  // Expose the count only when this entry matched
  assign cnt_sel = hit ? count : '0;

  // Control state: valid and match flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        hit   <= eff_valid && (key == key_in);
        valid <= eff_valid;
      end else if (ctl.ins && !valid && prev_valid) begin
        valid <= 1'b1;
      end
    end
  end

  // Payload: key and saturating count
  always_ff @(posedge clk) begin
    if (ctl.inc && hit) begin
      if (count != CNT_MAX) begin
        count <= count + CNT_W'(1);
      end
    end else if (ctl.ins && !valid && prev_valid) begin
      key   <= key_in;
      count <= CNT_W'(1);
    end
  end

endmodule

@@ hw/rtl/canonical_row_mode_counter.sv @@
// ----------------------------------------------------------------------------
// canonical_row_mode_counter: largest count of equal rows up to column flips
// Keys each row by its canonical form and counts keys in a cell table.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one matrix row per item: tdata = row bits, tuser = first
//   row of a matrix (clears the table and the best count), tlast = last row.
//   m_axis returns one item per row: tdata[8:0] = best count so far,
//   tuser = the new pattern could not be stored, tlast = echo of the row's
//   tlast. cfg writes row_width (valid columns, low bits); it is taken at any
//   time and should change only while the block is idle.
//   Each row passes from acceptance to the result register in order: the row
//   is canonicalized as it is accepted, then the parallel compare in all 256
//   cells, the registered 16-by-16 OR tree that gathers the match and its
//   count, and last the update of the table and the best count. One row is
//   in work at a time: a new row is accepted only once the block is back in
//   idle after the update of the last one.
//   Reset clears all entry valid bits at once, the best count, and sets
//   row_width to 64. A new row may be accepted while a result waits; that
//   row holds in the update step until the result is taken, and no further
//   row is accepted meanwhile.
// ----------------------------------------------------------------------------
module canonical_row_mode_counter
  import crmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // config write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WIDTH_W-1:0]  cfg_data,     // row_width
  // row input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ROW_BITS-1:0] s_axis_tdata,  // [63:0] row_bits
  input  logic                s_axis_tuser,  // [0] first_row
  input  logic                s_axis_tlast,  // last_row
  // result output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // [8:0] best_count, [15:9] zero
  output logic                m_axis_tuser,  // [0] table_full
  output logic                m_axis_tlast   // is_final
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_RED1 = 3'd2;
  localparam logic [2:0] ST_RED2 = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  logic [2:0]          state;
  logic [WIDTH_W-1:0]  row_width;
  logic [WIDTH_W-1:0]  width_eff;
  logic [ROW_BITS-1:0] width_mask;
  logic [ROW_BITS-1:0] key;
  logic                first_q;
  logic                last_q;
  cell_ctl_t           ctl;
  logic [NUM_CELLS-1:0] valid_vec;
  logic [NUM_CELLS-1:0] hit_vec;
  logic [CNT_W-1:0]     cnt_vec [NUM_CELLS];
  logic [NUM_GROUPS-1:0] grp_hit;
  logic [NUM_GROUPS-1:0] grp_hit_next;
  logic [CNT_W-1:0]      grp_cnt [NUM_GROUPS];
  logic [CNT_W-1:0]      grp_cnt_next [NUM_GROUPS];
  logic                  any_hit;
  logic [CNT_W-1:0]      hit_cnt;
  logic [CNT_W-1:0]      hit_cnt_next;
  logic [CNT_W-1:0]      best;
  logic [CNT_W-1:0]      row_cnt;
  logic                  full_now;
  logic                  upd_go;
  logic [CNT_W-1:0]      out_best;
  logic                  out_full;
  logic                  out_final;

  // Config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= WIDTH_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      row_width <= cfg_data;
    end
  end

  // Clamp the width and build the column mask
  always_comb begin
    if (row_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (row_width > WIDTH_DEFAULT) begin
      width_eff = WIDTH_DEFAULT;
    end else begin
      width_eff = row_width;
    end
    for (int j = 0; j < ROW_BITS; j++) begin
      width_mask[j] = WIDTH_W'(j) < width_eff;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign upd_go   = (state == ST_UPD) && (!m_axis_tvalid || m_axis_tready);
  assign full_now = valid_vec[NUM_CELLS-1];

  // Canonicalize the row on acceptance
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key     <= (s_axis_tdata ^ {ROW_BITS{s_axis_tdata[0]}}) & width_mask;
      first_q <= s_axis_tuser;
      last_q  <= s_axis_tlast;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (s_axis_tvalid) state <= ST_CMP;
        ST_CMP:  state <= ST_RED1;
        ST_RED1: state <= ST_RED2;
        ST_RED2: state <= ST_UPD;
        ST_UPD:  if (upd_go) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Cell control
  always_comb begin
    ctl.clear = (state == ST_CMP) && first_q;
    ctl.cmp   = (state == ST_CMP);
    ctl.inc   = (state == ST_RED1);
    ctl.ins   = upd_go && !any_hit && !full_now;
  end

  // Table: chain of cells, each linked to its left neighbor's valid bit
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    crmc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key_in     (key),
      .prev_valid ((i == 0) ? 1'b1 : valid_vec[(i == 0) ? 0 : i-1]),
      .valid      (valid_vec[i]),
      .hit        (hit_vec[i]),
      .cnt_sel    (cnt_vec[i])
    );
  end

  // First tree level: OR within each group of cells
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hit_next[g] = |hit_vec[g*GROUP_SIZE +: GROUP_SIZE];
      grp_cnt_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        grp_cnt_next[g] = grp_cnt_next[g] | cnt_vec[g*GROUP_SIZE + k];
      end
    end
  end

  // Second tree level: OR across groups
  always_comb begin
    hit_cnt_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      hit_cnt_next = hit_cnt_next | grp_cnt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RED1) begin
      grp_hit <= grp_hit_next;
      grp_cnt <= grp_cnt_next;
    end
    if (state == ST_RED2) begin
      any_hit <= |grp_hit;
      hit_cnt <= hit_cnt_next;
    end
  end

  // Count of this row's pattern after the update
  always_comb begin
    if (any_hit) begin
      row_cnt = (hit_cnt == CNT_MAX) ? CNT_MAX : hit_cnt + CNT_W'(1);
    end else if (full_now) begin
      row_cnt = '0;
    end else begin
      row_cnt = CNT_W'(1);
    end
  end

  // Best count: clear on a first row, raise on update
  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else if (ctl.clear) begin
      best <= '0;
    end else if (upd_go && row_cnt > best) begin
      best <= row_cnt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (upd_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_best  <= (row_cnt > best) ? row_cnt : best;
      out_full  <= !any_hit && full_now;
      out_final <= last_q;
    end
  end

  assign m_axis_tdata = {{(16-CNT_W){1'b0}}, out_best};
  assign m_axis_tuser = out_full;
  assign m_axis_tlast = out_final;

  // Used entries always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + NUM_CELLS'(1))) == '0)
    else $error("table entries are not a contiguous prefix");

  // A key matches at most one entry
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RED1) |-> $onehot0(hit_vec))
    else $error("key matched more than one entry");

  // Best count only drops on a first row
  a_best_mono: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |=> (best >= $past(best)))
    else $error("best count decreased without a first row");

  // A pattern dropped on a full table is flagged on its result
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (upd_go && !any_hit && full_now) |=> (m_axis_tvalid && m_axis_tuser))
    else $error("dropped pattern not flagged as table_full");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for canonical_row_mode_counter
// Streams matrix rows into the block and predicts each result with a pattern
// table of its own: canonical keys, per-key counts with saturation, drops once
// the table is full, and the best count per matrix. Both stream sides idle and
// stall at random, and the row width register is swept between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import crmc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PRESS_CYCLES = 300;
  localparam int TARGET_ROWS  = 1050;

  typedef struct packed {
    logic [ROW_BITS-1:0] bits;
    logic                first;
    logic                last;
  } row_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] best;
    logic             is_last;
    logic             full;
  } count_item_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [WIDTH_W-1:0]  cfg_data      = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ROW_BITS-1:0] s_axis_tdata  = '0;  // [63:0] row_bits
  logic                s_axis_tuser  = 1'b0;  // [0] first_row
  logic                s_axis_tlast  = 1'b0;  // last_row
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;  // [8:0] best_count, [15:9] zero
  logic                m_axis_tuser;  // [0] table_full
  logic                m_axis_tlast;  // is_final

  // Rows waiting to be sent and counts waiting to come back
  row_item_t   rows_to_send[$];
  count_item_t pending_counts[$];

  // Predicted pattern table and register copy
  logic [ROW_BITS-1:0] key_tab [NUM_CELLS];
  logic [CNT_W-1:0]    hits_tab[NUM_CELLS];
  int                  keys_used = 0;
  logic [CNT_W-1:0]    best_run  = '0;
  logic [WIDTH_W-1:0]  width_reg = WIDTH_DEFAULT;

  // Flow control between processes
  logic row_taken   = 1'b0;
  logic burst       = 1'b0;
  logic press_req   = 1'b0;
  logic press_done  = 1'b0;
  int   send_gap    = 0;
  int   send_calm   = 0;
  int   take_hold   = 0;
  int   take_calm   = 0;
  int   idle_cycles = 0;

  // Run statistics
  int errors          = 0;
  int rows_queued     = 0;
  int results_checked = 0;
  int full_seen       = 0;
  int widths_written  = 0;
  int max_best        = 0;

  canonical_row_mode_counter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mask of the valid columns; width 0 acts as 1, above ROW_BITS as ROW_BITS
  function automatic logic [ROW_BITS-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    int n;
    n = int'(w);
    if (n < 1) n = 1;
    if (n > ROW_BITS) n = ROW_BITS;
    if (n >= ROW_BITS) return '1;
    return (ROW_BITS'(1) << n) - ROW_BITS'(1);
  endfunction

  function automatic logic [ROW_BITS-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly no wait, some short waits, a few long ones, and calm stretches
  function automatic int pick_wait(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Update the predicted table with one row and return its expected result
  function automatic count_item_t count_row(input row_item_t it);
    logic [ROW_BITS-1:0] key;
    logic [CNT_W-1:0]    cnt;
    logic                hit;
    count_item_t         res;
    key = (it.bits ^ {ROW_BITS{it.bits[0]}}) & width_mask(width_reg);
    if (it.first) begin
      keys_used = 0;
      best_run  = '0;
    end
    cnt      = '0;
    hit      = 1'b0;
    res.full = 1'b0;
    for (int i = 0; i < keys_used; i++) begin
      if (!hit && key_tab[i] == key) begin
        if (hits_tab[i] != CNT_MAX) hits_tab[i] = hits_tab[i] + CNT_W'(1);
        cnt = hits_tab[i];
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (keys_used < NUM_CELLS) begin
        key_tab[keys_used]  = key;
        hits_tab[keys_used] = CNT_W'(1);
        keys_used++;
        cnt = CNT_W'(1);
      end else begin
        res.full = 1'b1;
      end
    end
    if (cnt > best_run) best_run = cnt;
    res.best    = best_run;
    res.is_last = it.last;
    return res;
  endfunction

  // Row driver: hold the item until taken, then wait out a random gap
  always @(negedge clk) begin
    row_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || row_taken) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (rows_to_send.size() > 0) begin
        nxt = rows_to_send.pop_front();
        s_axis_tdata  <= nxt.bits;
        s_axis_tuser  <= nxt.first;
        s_axis_tlast  <= nxt.last;
        s_axis_tvalid <= 1'b1;
        send_gap      <= burst ? 0 : pick_wait(send_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (press_req && !press_done) begin
      press_done    <= 1'b1;
      take_hold     <= PRESS_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (take_hold > 0) begin
      take_hold     <= take_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      take_hold     <= pick_wait(take_calm);
    end
  end

  // Monitor: predict on each accepted row, check each accepted result
  always @(posedge clk) begin
    count_item_t want;
    if (rst) begin
      row_taken <= 1'b0;
    end else begin
      row_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        pending_counts.push_back(count_row(row_item_t'{s_axis_tdata, s_axis_tuser,
                                                       s_axis_tlast}));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_counts.size() == 0) begin
          $error("result with no row pending: best_count %0d", m_axis_tdata[CNT_W-1:0]);
          errors++;
        end else begin
          want = pending_counts.pop_front();
          results_checked++;
          if (want.full) full_seen++;
          if (want.best > max_best) max_best = want.best;
          if (m_axis_tdata[CNT_W-1:0] !== want.best) begin
            $error("best_count: expected %0d, got %0d", want.best, m_axis_tdata[CNT_W-1:0]);
            errors++;
          end
          if (m_axis_tlast !== want.is_last) begin
            $error("is_final: expected %0b, got %0b", want.is_last, m_axis_tlast);
            errors++;
          end
          if (m_axis_tuser !== want.full) begin
            $error("table_full: expected %0b, got %0b", want.full, m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_row(input logic [ROW_BITS-1:0] bits, input logic first,
                         input logic last);
    rows_to_send.push_back(row_item_t'{bits, first, last});
    rows_queued++;
  endtask

  // Wait until every row is sent and answered, then let the pipe drain
  task automatic wait_idle();
    while (rows_to_send.size() != 0 || s_axis_tvalid || pending_counts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_width(input logic [WIDTH_W-1:0] w);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    width_reg = w;
    widths_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [ROW_BITS-1:0] r;
    logic [ROW_BITS-1:0] mask;
    logic [ROW_BITS-1:0] pool[6];
    logic [ROW_BITS-1:0] stored_rows[NUM_CELLS];
    logic [WIDTH_W-1:0]  w;
    int                  len;
    int                  npool;
    logic                fresh;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset width: a row and its complement share a key
    add_row('0, 1'b1, 1'b0);
    add_row('1, 1'b0, 1'b0);
    add_row({32{2'b10}}, 1'b0, 1'b0);
    add_row({32{2'b01}}, 1'b0, 1'b0);
    add_row({1'b1, 63'd0}, 1'b0, 1'b0);
    add_row({1'b0, {63{1'b1}}}, 1'b0, 1'b0);
    add_row(64'd1, 1'b0, 1'b0);
    add_row(~64'd1, 1'b0, 1'b0);
    add_row('0, 1'b0, 1'b1);
    add_row(rand64(), 1'b1, 1'b1);
    // Without a first row, keep accumulating into the same table
    add_row('1, 1'b0, 1'b0);
    add_row('0, 1'b0, 1'b1);

    // Width 0 acts as one column: every row has the same key
    set_width('0);
    add_row(rand64(), 1'b1, 1'b0);
    add_row(rand64(), 1'b0, 1'b0);
    add_row(rand64(), 1'b0, 1'b1);

    // Width above the row size acts as the full row
    set_width('1);
    add_row({1'b1, 63'd0}, 1'b1, 1'b0);
    add_row('0, 1'b0, 1'b1);

    // Top column masked off
    set_width(WIDTH_W'(ROW_BITS - 1));
    add_row({1'b1, 63'd0}, 1'b1, 1'b0);
    add_row('0, 1'b0, 1'b1);

    // Fill the table past capacity with distinct keys, sender never idle
    burst = 1'b1;
    set_width(WIDTH_DEFAULT);
    for (int i = 0; i < NUM_CELLS + 4; i++) begin
      r      = rand64();
      r[0]   = 1'b0;
      r[9:1] = 9'(i);
      if (i < NUM_CELLS) stored_rows[i] = r;
      add_row(r, i == 0, 1'b0);
    end
    @(posedge clk);
    press_req = 1'b1;
    // Mix hits on stored keys with new keys that must be dropped
    for (int i = 0; i < 12; i++) begin
      if ($urandom_range(0, 1)) begin
        r      = rand64();
        r[0]   = 1'b0;
        r[9:1] = 9'(NUM_CELLS + 4 + i);
      end else begin
        r = stored_rows[$urandom_range(0, NUM_CELLS - 1)];
        if ($urandom_range(0, 1)) r = ~r;
      end
      add_row(r, 1'b0, i == 11);
    end
    wait_idle();
    burst = 1'b0;

    // One column only: one key whose count runs into saturation
    set_width(WIDTH_W'(1));
    for (int i = 0; i < 520; i++) add_row(rand64(), i == 0, i == 519);

    // Random matrices built from a small pool of rows, with noise
    while (rows_queued < TARGET_ROWS) begin
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = WIDTH_W'(ROW_BITS);
        2:       w = '1;
        3, 4:    w = WIDTH_W'($urandom_range(1, 127));
        default: w = WIDTH_W'($urandom_range(1, 8));
      endcase
      set_width(w);
      mask = width_mask(w);
      repeat (3) begin
        len   = $urandom_range(1, 40);
        npool = $urandom_range(1, 6);
        for (int k = 0; k < npool; k++) pool[k] = rand64();
        fresh = $urandom_range(0, 9) != 0;
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 4) == 0) begin
            r = rand64();
          end else begin
            r = pool[$urandom_range(0, npool - 1)];
            if ($urandom_range(0, 1)) r = ~r;
            // Columns above the width must not change the key
            r = r ^ (rand64() & ~mask);
          end
          add_row(r, fresh && j == 0, j == len - 1 && $urandom_range(0, 9) != 0);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_counts.size() != 0) begin
      $error("%0d expected results never arrived", pending_counts.size());
      errors++;
    end
    $display("Sent %0d rows over %0d width settings; checked %0d results.",
             rows_queued, widths_written, results_checked);
    $display("Saw %0d dropped-pattern results; highest best count %0d.",
             full_seen, max_best);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
